// ----- src/afa_pkg.sv -----
// Package for the arena frame allocator: sizes, command codes and shared types.
// No dependencies.
`default_nettype none
package afa_pkg;
    localparam int NUM_SLOTS = 4;
    localparam int FRAME_DEPTH = 256;
    localparam int CHECKPOINT_DEPTH = 8;
    localparam int OFFSET_BITS = 31;
    localparam int GEN_BITS = 16;
    localparam int SLOT_BITS = 2;
    localparam int FIDX_BITS = $clog2(FRAME_DEPTH);
    localparam int FCNT_BITS = FIDX_BITS + 1;
    localparam int CIDX_BITS = (CHECKPOINT_DEPTH > 1) ? $clog2(CHECKPOINT_DEPTH) : 1;
    localparam int CCNT_BITS = $clog2(CHECKPOINT_DEPTH + 1);
    localparam int FADDR_BITS = SLOT_BITS + FIDX_BITS;
    localparam logic [31:0] PAYLOAD_LIMIT = 32'h4000_0000;

    typedef enum logic [2:0] {
        CMD_ALLOC = 3'd0, CMD_FREE = 3'd1, CMD_CONTAINS = 3'd2,
        CMD_CHECKPOINT = 3'd3, CMD_ROLLBACK = 3'd4, CMD_DESTROY = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        REG_LIVE = 3'd0, REG_CAP0 = 3'd1, REG_CAP1 = 3'd2, REG_CAP2 = 3'd3, REG_CAP3 = 3'd4
    } reg_t;

    // One frame record as held in the frame memory.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] payload;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] fend;
        logic                   dead;
    } frame_t;

    // Request from the sequencer to the frame memory.
    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic [FADDR_BITS-1:0] addr;
        frame_t                wdata;
    } fmem_req_t;

    function automatic logic [OFFSET_BITS+1:0] round8(input logic [OFFSET_BITS+1:0] x);
        logic [OFFSET_BITS+1:0] t;
        t = x + (OFFSET_BITS+2)'(7);
        return {t[OFFSET_BITS+1:3], 3'b000};
    endfunction
endpackage
`default_nettype wire

// ----- src/arena_frame_allocator_with_checkpoints_top.sv -----
// Top level of the arena frame allocator with checkpoint stack.
// Depends on afa_pkg and afa_frame_mem.
//
//  Channel  | Signals                                          | Handshake
//  command  | cmd slot header_bytes payload_bytes address      | start && !busy
//  result   | ok value                                         | done, one cycle
//  config   | cfg_index cfg_data                               | cfg_valid && cfg_ready
//
// Alloc, contains, checkpoint and destroy pass from acceptance through the execute
// and done states. Free runs a search pass over the slot's frames (a read and a
// compare per frame, top down), marks a matching frame dead and then runs a pop
// pass over the dead frames at the top; rollback, when the entry is restored, runs
// a pop pass that prunes the frames at or above the restored offset. The frame
// memory has a single read port. Reset clears counts, offsets and generations;
// frame records are only read below the count, so the memory needs no clearing
// pass. The receiver cannot stall: done lasts one cycle.
`default_nettype none
module arena_frame_allocator_with_checkpoints_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    cmd,
    input  wire logic [1:0]                    slot,
    input  wire logic [15:0]                   header_bytes,
    input  wire logic [30:0]                   payload_bytes,
    input  wire logic [30:0]                   address,
    output logic                               done,
    output logic                               ok,
    output logic [30:0]                        value,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [30:0]                   cfg_data
);
    import afa_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_EXEC  = 8'b0000_0010,
        ST_SRCH  = 8'b0000_0100,  // free: look for matching payload, top down
        ST_SWAIT = 8'b0000_1000,
        ST_POP   = 8'b0001_0000,  // pop dead frames / prune on rollback
        ST_PWAIT = 8'b0010_0000,
        ST_DONE  = 8'b0100_0000,
        ST_MARK  = 8'b1000_0000   // write the dead flag back
    } state_t;

    state_t state_reg, state_next;
    logic [3:0]             live_reg;
    logic [OFFSET_BITS-1:0] cap_reg [NUM_SLOTS];
    logic [OFFSET_BITS-1:0] off_reg [NUM_SLOTS];
    logic [GEN_BITS-1:0]    gen_reg [NUM_SLOTS];
    logic [FCNT_BITS-1:0]   fcnt_reg [NUM_SLOTS];
    logic [CCNT_BITS-1:0]   ccnt_reg;
    // Checkpoint memory.
    logic [SLOT_BITS+OFFSET_BITS+GEN_BITS-1:0] ckpt_mem [CHECKPOINT_DEPTH];
    logic [SLOT_BITS+OFFSET_BITS+GEN_BITS-1:0] ckpt_rd;

    cmd_t                   cmd_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [15:0]            hdr_reg;
    logic [30:0]            pay_reg;
    logic [30:0]            addr_reg;
    logic [FCNT_BITS-1:0]   k_reg;     // walk position: frame index + 1
    logic                   rb_reg;    // current pop pass prunes for rollback
    logic [OFFSET_BITS-1:0] rboff_reg;
    logic                   ok_reg;
    logic [30:0]            val_reg;
    logic                   done_reg;

    fmem_req_t fmem_req;
    frame_t    frd;

    afa_frame_mem u_fmem (.clk(clk), .req(fmem_req), .rdata(frd));

    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done = done_reg;
    assign ok = ok_reg;
    assign value = val_reg;

    // Alloc arithmetic.
    logic [OFFSET_BITS+1:0] cur_w, hsz_w, end_w;
    always_comb
    begin
        cur_w = round8({2'b00, off_reg[slot_reg]});
        hsz_w = round8((OFFSET_BITS+2)'(hdr_reg));
        end_w = cur_w + hsz_w + (OFFSET_BITS+2)'(pay_reg);
    end

    logic [SLOT_BITS+OFFSET_BITS+GEN_BITS-1:0] ck_new;
    logic [SLOT_BITS-1:0]   ck_slot;
    logic [OFFSET_BITS-1:0] ck_off;
    logic [GEN_BITS-1:0]    ck_gen;
    assign ck_new = {slot_reg, off_reg[slot_reg], gen_reg[slot_reg]};
    assign {ck_slot, ck_off, ck_gen} = ckpt_rd;

    // Checkpoint push succeeds on a live slot with room on the stack; a popped
    // entry is restored only if its slot is live, its generation still matches
    // and its offset fits the current capacity.
    logic ck_ok, rb_ok;
    assign ck_ok = live_reg[slot_reg] && ccnt_reg < CCNT_BITS'(CHECKPOINT_DEPTH);
    assign rb_ok = (ccnt_reg != '0) && live_reg[ck_slot]
        && gen_reg[ck_slot] == ck_gen && ck_off <= cap_reg[ck_slot];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC && cmd_reg == CMD_CHECKPOINT && ck_ok)
            ckpt_mem[ccnt_reg[CIDX_BITS-1:0]] <= ck_new;
        if (state_reg == ST_IDLE && start)
            ckpt_rd <= ckpt_mem[CIDX_BITS'(ccnt_reg - CCNT_BITS'(1))];
    end

    // Frame memory request.
    logic [FIDX_BITS-1:0] kidx;
    assign kidx = FIDX_BITS'(k_reg - FCNT_BITS'(1));
    always_comb
    begin
        fmem_req = '0;
        fmem_req.addr = {slot_reg, kidx};
        unique case (state_reg)
            ST_EXEC:
            begin
                fmem_req.addr = {slot_reg, fcnt_reg[slot_reg][FIDX_BITS-1:0]};
                fmem_req.wdata.payload = OFFSET_BITS'(cur_w + hsz_w);
                fmem_req.wdata.start = OFFSET_BITS'(cur_w);
                fmem_req.wdata.fend = OFFSET_BITS'(round8(end_w));
                fmem_req.wr = cmd_reg == CMD_ALLOC && pay_reg <= PAYLOAD_LIMIT[30:0]
                    && live_reg[slot_reg] && fcnt_reg[slot_reg] < FCNT_BITS'(FRAME_DEPTH)
                    && end_w <= {2'b00, cap_reg[slot_reg]};
            end
            ST_SRCH, ST_POP: fmem_req.rd = (k_reg != '0);
            ST_MARK:
            begin
                fmem_req.wr = 1'b1;
                fmem_req.wdata = frd;
                fmem_req.wdata.dead = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            live_reg <= '0;
            ccnt_reg <= '0;
            done_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cap_reg[i] <= '0;
                off_reg[i] <= '0;
                gen_reg[i] <= '0;
                fcnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_LIVE: live_reg <= cfg_data[3:0];
                    REG_CAP0: cap_reg[0] <= cfg_data;
                    REG_CAP1: cap_reg[1] <= cfg_data;
                    REG_CAP2: cap_reg[2] <= cfg_data;
                    REG_CAP3: cap_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_EXEC:
                begin
                    unique case (cmd_reg)
                        CMD_ALLOC:
                            if (fmem_req.wr)
                            begin
                                off_reg[slot_reg] <= fmem_req.wdata.fend;
                                fcnt_reg[slot_reg] <= fcnt_reg[slot_reg] + FCNT_BITS'(1);
                            end
                        CMD_CHECKPOINT:
                            if (ck_ok)
                                ccnt_reg <= ccnt_reg + CCNT_BITS'(1);
                        CMD_ROLLBACK:
                            if (ccnt_reg != '0)
                            begin
                                ccnt_reg <= ccnt_reg - CCNT_BITS'(1);
                                if (rb_ok)
                                    off_reg[ck_slot] <= ck_off;
                            end
                        CMD_DESTROY:
                        begin
                            fcnt_reg[slot_reg] <= '0;
                            off_reg[slot_reg] <= '0;
                            gen_reg[slot_reg] <= gen_reg[slot_reg] + GEN_BITS'(1);
                        end
                        default: ;
                    endcase
                end
                ST_PWAIT:
                    if (rb_reg ? (frd.start >= rboff_reg) : frd.dead)
                    begin
                        if (!rb_reg && frd.fend == off_reg[slot_reg])
                            off_reg[slot_reg] <= frd.start;
                        fcnt_reg[slot_reg] <= FCNT_BITS'(kidx);
                    end
                ST_DONE: done_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers and walk control.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (start)
                begin
                    cmd_reg <= cmd_t'(cmd);
                    slot_reg <= slot;
                    hdr_reg <= header_bytes;
                    pay_reg <= payload_bytes;
                    addr_reg <= address;
                    ok_reg <= 1'b0;
                    val_reg <= '0;
                    rb_reg <= 1'b0;
                end
            ST_EXEC:
            begin
                k_reg <= (cmd_reg == CMD_ROLLBACK) ? fcnt_reg[ck_slot] : fcnt_reg[slot_reg];
                unique case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        ok_reg <= fmem_req.wr;
                        val_reg <= fmem_req.wr ? fmem_req.wdata.payload : '0;
                    end
                    CMD_FREE, CMD_CONTAINS: ok_reg <= addr_reg < cap_reg[slot_reg];
                    CMD_CHECKPOINT:
                    begin
                        ok_reg <= ck_ok;
                        val_reg <= ck_ok ? 31'(ccnt_reg) : '0;
                    end
                    CMD_ROLLBACK:
                    begin
                        ok_reg <= rb_ok;
                        val_reg <= rb_ok ? 31'(ck_slot) : '0;
                        slot_reg <= ck_slot;
                        rb_reg <= 1'b1;
                        rboff_reg <= ck_off;
                    end
                    CMD_DESTROY: ok_reg <= 1'b1;
                    default: ;
                endcase
            end
            // No matching frame: the pop pass starts again from the top.
            ST_SRCH:
                if (k_reg == '0)
                    k_reg <= fcnt_reg[slot_reg];
            ST_SWAIT:
                if (frd.payload != addr_reg)
                    k_reg <= k_reg - FCNT_BITS'(1);
            ST_MARK: k_reg <= fcnt_reg[slot_reg];
            ST_PWAIT:
                if (rb_reg ? (frd.start >= rboff_reg) : frd.dead)
                    k_reg <= k_reg - FCNT_BITS'(1);
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC:
                if (cmd_reg == CMD_FREE && addr_reg < cap_reg[slot_reg])
                    state_next = ST_SRCH;
                else if (rb_ok && cmd_reg == CMD_ROLLBACK)
                    state_next = ST_POP;
                else
                    state_next = ST_DONE;
            ST_SRCH:  state_next = (k_reg == '0) ? ST_POP : ST_SWAIT;
            ST_SWAIT: state_next = (frd.payload == addr_reg) ? ST_MARK : ST_SRCH;
            ST_MARK:  state_next = ST_POP;
            ST_POP:   state_next = (k_reg == '0) ? ST_DONE : ST_PWAIT;
            ST_PWAIT: state_next = (rb_reg ? (frd.start >= rboff_reg) : frd.dead)
                                   ? ST_POP : ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // A result lasts one cycle and appears only once the block is idle again.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done);
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy);
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg));
    a_ckpt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ccnt_reg <= CCNT_BITS'(CHECKPOINT_DEPTH));
endmodule
`default_nettype wire

// ----- src/afa_frame_mem.sv -----
// Frame memory: one record per slot and frame level, registered read.
// Depends on afa_pkg.
`default_nettype none
module afa_frame_mem (
    input  wire logic               clk,
    input  wire afa_pkg::fmem_req_t req,
    output afa_pkg::frame_t         rdata
);
    import afa_pkg::*;
    frame_t mem [NUM_SLOTS*FRAME_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr)
            mem[req.addr] <= req.wdata;
        if (req.rd)
            rdata <= mem[req.addr];
    end
endmodule
`default_nettype wire
